// ----- design/xabe_pkg.sv -----
`timescale 1ns / 1ps

package xabe_pkg;

   typedef enum logic [3:0] {
      OP_MOV    = 4'd0,
      OP_ADD    = 4'd1,
      OP_SUB    = 4'd2,
      OP_CMP    = 4'd3,
      OP_JB     = 4'd4,
      OP_JE     = 4'd5,
      OP_JNZ    = 4'd6,
      OP_JP     = 4'd7,
      OP_LOOPNZ = 4'd8,
      OP_HLT    = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_UNIMPL   = 2'd1,
      ERR_BYTE     = 2'd2,
      ERR_OPERANDS = 2'd3
   } err_type;

   // flag bit positions
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_P = 1;
   localparam int unsigned FLAG_A = 2;
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_S = 4;
   localparam int unsigned FLAG_O = 5;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned FLAGS_W = 6;

   typedef struct packed {
      logic               write_first;
      logic [WORD_W-1:0]  first_result;
      logic               write_is_wide;
      logic               write_count;
      logic [WORD_W-1:0]  count_result;
      logic [WORD_W-1:0]  next_ip;
      logic [FLAGS_W-1:0] flag_bits;
      logic               stop;
      logic [1:0]         error;
   } rsp_type;

   typedef struct packed {
      logic [3:0]        operation;
      logic [2:0]        instr_size;
      logic [1:0]        operand_count;
      logic              wide;
      logic [WORD_W-1:0] first_value;
      logic [WORD_W-1:0] second_value;
      logic [WORD_W-1:0] count_value;
   } req_type;

endpackage

// ----- design/x86_alu_branch_execute_unit.sv -----
`timescale 1ns / 1ps

// Executes one decoded 16-bit instruction (mov, add, sub, cmp, jb, je, jnz, jp, loopnz,
// hlt) per beat and keeps the instruction pointer and the six status flags internally;
// both clear on reset. A beat is taken into an input register, executed in combinational
// logic against the current pointer and flags, and then lands in the result register;
// one instruction is taken every cycle while the result side keeps up. The pointer and
// flag update happen when the beat moves into the result register, which lets the next
// instruction see them right away.
// A stop result (hlt or error) does not halt the block; the next beat executes normally.
module x86_alu_branch_execute_unit
   import xabe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_operation,
   input  logic [2:0]  req_instr_size,
   input  logic [1:0]  req_operand_count,
   input  logic        req_wide,
   input  logic [15:0] req_first_value,
   input  logic [15:0] req_second_value,
   input  logic [15:0] req_count_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_first,
   output logic [15:0] rsp_first_result,
   output logic        rsp_write_is_wide,
   output logic        rsp_write_count,
   output logic [15:0] rsp_count_result,
   output logic [15:0] rsp_next_ip,
   output logic [5:0]  rsp_flag_bits,
   output logic        rsp_stop,
   output logic [1:0]  rsp_error
);

   logic                req_valid_ff, req_valid_in;
   req_type             req_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [WORD_W-1:0]   ip_ff, ip_in;
   logic [FLAGS_W-1:0]  flags_ff, flags_in;
   logic                req_fire, advance, arith_done;

   logic [WORD_W-1:0]   ip_step;
   logic [WORD_W:0]     sum_w, diff_w;
   logic [WORD_W-1:0]   alu_r, ov_v;
   logic                alu_c, take;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_valid && !rsp_stall ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ip_ff        <= '0;
         flags_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            ip_ff    <= ip_in;
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff.operation     <= req_operation;
         req_ff.instr_size    <= req_instr_size;
         req_ff.operand_count <= req_operand_count;
         req_ff.wide          <= req_wide;
         req_ff.first_value   <= req_first_value;
         req_ff.second_value  <= req_second_value;
         req_ff.count_value   <= req_count_value;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // execute
   always_comb begin
      ip_step = ip_ff + WORD_W'(req_ff.instr_size);
      sum_w   = {1'b0, req_ff.first_value} + {1'b0, req_ff.second_value};
      diff_w  = {1'b0, req_ff.first_value} - {1'b0, req_ff.second_value};
      if (req_ff.operation == OP_ADD) begin
         alu_r = sum_w[WORD_W-1:0];
         alu_c = sum_w[WORD_W];
         ov_v  = ~(req_ff.first_value ^ req_ff.second_value)
                 & (req_ff.first_value ^ alu_r);
      end else begin
         alu_r = diff_w[WORD_W-1:0];
         alu_c = diff_w[WORD_W];
         ov_v  = (req_ff.first_value ^ req_ff.second_value)
                 & (req_ff.first_value ^ alu_r);
      end

      rsp_in     = '0;
      ip_in      = ip_step;
      flags_in   = flags_ff;
      take       = 1'b0;
      arith_done = 1'b0;
      rsp_in.count_result = req_ff.count_value - WORD_W'(1);

      case (req_ff.operation)
         OP_MOV: begin
            if (req_ff.operand_count != 2'd2) begin
               rsp_in.stop  = 1'b1;
               rsp_in.error = ERR_OPERANDS;
            end else begin
               rsp_in.write_first   = 1'b1;
               rsp_in.write_is_wide = req_ff.wide;
               rsp_in.first_result  = req_ff.wide ? req_ff.second_value
                                      : {8'd0, req_ff.second_value[7:0]};
            end
         end
         OP_ADD, OP_SUB, OP_CMP: begin
            if (req_ff.operand_count != 2'd2) begin
               rsp_in.stop  = 1'b1;
               rsp_in.error = ERR_OPERANDS;
            end else if (!req_ff.wide) begin
               rsp_in.stop  = 1'b1;
               rsp_in.error = ERR_BYTE;
            end else begin
               arith_done       = 1'b1;
               flags_in[FLAG_C] = alu_c;
               flags_in[FLAG_P] = ~^alu_r[7:0];
               // carry or borrow out of bit 3
               flags_in[FLAG_A] = req_ff.first_value[4] ^ req_ff.second_value[4] ^ alu_r[4];
               flags_in[FLAG_Z] = (alu_r == '0);
               flags_in[FLAG_S] = alu_r[WORD_W-1];
               flags_in[FLAG_O] = ov_v[WORD_W-1];
               if (req_ff.operation != OP_CMP) begin
                  rsp_in.write_first   = 1'b1;
                  rsp_in.write_is_wide = 1'b1;
                  rsp_in.first_result  = alu_r;
               end
            end
         end
         OP_JB, OP_JE, OP_JNZ, OP_JP, OP_LOOPNZ: begin
            if (req_ff.operand_count == 2'd0) begin
               rsp_in.stop  = 1'b1;
               rsp_in.error = ERR_OPERANDS;
            end else begin
               case (req_ff.operation)
                  OP_JB:   take = flags_ff[FLAG_C];
                  OP_JE:   take = flags_ff[FLAG_Z];
                  OP_JNZ:  take = !flags_ff[FLAG_Z];
                  OP_JP:   take = flags_ff[FLAG_P];
                  default: begin
                     rsp_in.write_count = 1'b1;
                     take = (rsp_in.count_result != '0) && !flags_ff[FLAG_Z];
                  end
               endcase
               if (take) begin
                  ip_in = ip_step + req_ff.first_value;
               end
            end
         end
         OP_HLT: begin
            rsp_in.stop = 1'b1;
         end
         default: begin
            rsp_in.stop  = 1'b1;
            rsp_in.error = ERR_UNIMPL;
         end
      endcase

      if (!rsp_in.write_count) begin
         rsp_in.count_result = '0;
      end
      rsp_in.next_ip   = ip_in;
      rsp_in.flag_bits = flags_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_first   = rsp_ff.write_first;
   assign rsp_first_result  = rsp_ff.first_result;
   assign rsp_write_is_wide = rsp_ff.write_is_wide;
   assign rsp_write_count   = rsp_ff.write_count;
   assign rsp_count_result  = rsp_ff.count_result;
   assign rsp_next_ip       = rsp_ff.next_ip;
   assign rsp_flag_bits     = rsp_ff.flag_bits;
   assign rsp_stop          = rsp_ff.stop;
   assign rsp_error         = rsp_ff.error;

   a_write_no_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_first |-> !rsp_stop)
      else $error("write-back together with stop");

   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != ERR_NONE |-> rsp_stop)
      else $error("error without stop");

   a_flags_only_arith: assert property (@(posedge clock) disable iff (reset)
      advance && !arith_done |=> flags_ff == $past(flags_ff))
      else $error("flags changed on non-arithmetic beat");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_next_ip == ip_ff && rsp_flag_bits == flags_ff)
      else $error("result out of step with pointer or flags");

endmodule
